>>> src/nnps_pkg.sv
package nnps_pkg;

    // Field widths
    localparam int DIM_BITS       = 14;
    localparam int FRAC_BITS      = 16;
    localparam int ACC_BITS       = DIM_BITS + FRAC_BITS;
    localparam int PIXEL_BITS     = 32;
    localparam int CFG_INDEX_BITS = 3;

    typedef logic [DIM_BITS-1:0]       dim_t;
    typedef logic [ACC_BITS-1:0]       acc_t;
    typedef logic [PIXEL_BITS-1:0]     pixel_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_addr_t;

    // Register map
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ROW_PIXELS    = 3'd0,
        CFG_CROP_LEFT     = 3'd1,
        CFG_CROP_TOP      = 3'd2,
        CFG_SAMPLE_WIDTH  = 3'd3,
        CFG_SAMPLE_HEIGHT = 3'd4,
        CFG_DEST_WIDTH    = 3'd5,
        CFG_DEST_HEIGHT   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        pixel_t pixel_in;
        logic   frame_start;
    } nnps_in_t;

    typedef struct packed {
        pixel_t pixel_out;
        dim_t   out_column;
        dim_t   out_row;
        logic   last_of_frame;
    } nnps_out_t;

    typedef struct packed {
        dim_t row_pixels;
        dim_t crop_left;
        dim_t crop_top;
        dim_t sample_width;
        dim_t sample_height;
        dim_t dest_width;
        dim_t dest_height;
    } nnps_cfg_t;

endpackage

>>> src/nnps_divider.sv
module nnps_divider import nnps_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    input  acc_t dividend,
    input  dim_t divisor,
    output logic busy,
    output acc_t quotient
);

    localparam int CNT_BITS = $clog2(ACC_BITS + 1);

    logic                busy_reg;
    logic [CNT_BITS-1:0] count_reg;
    dim_t                rem_reg;
    acc_t                quo_reg;

    logic [DIM_BITS:0] rem_shift;
    logic [DIM_BITS:0] rem_diff;
    logic              fits;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        rem_shift = {rem_reg, quo_reg[ACC_BITS-1]};
        rem_diff  = rem_shift - {1'b0, divisor};
        fits      = (rem_shift >= {1'b0, divisor});
    end

    // Hold the dividend in the quotient register and shift quotient bits in behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_BITS'(ACC_BITS);
        end else if (busy_reg) begin
            count_reg <= count_reg - CNT_BITS'(1);
            busy_reg  <= (count_reg != CNT_BITS'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[ACC_BITS-2:0], fits};
            rem_reg <= fits ? rem_diff[DIM_BITS-1:0] : rem_shift[DIM_BITS-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> src/nnps_core.sv
module nnps_core import nnps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  nnps_cfg_t cfg,
    input  acc_t      col_quotient,
    input  acc_t      row_quotient,
    input  logic      step_busy,
    input  logic      s_valid,
    output logic      s_ready,
    input  nnps_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output nnps_out_t m_data
);

    // Input register
    logic     in_valid_reg;
    nnps_in_t in_reg;

    // Stream position state
    dim_t src_col_reg, src_row_reg;
    acc_t col_acc_reg, row_acc_reg;
    dim_t out_col_reg, out_row_reg;
    acc_t col_step_reg, row_step_reg;
    logic done_reg;

    // Result register
    logic      out_valid_reg;
    nnps_out_t out_reg;

    logic advance;
    logic degenerate;

    // Position state as seen by this request, after any frame restart
    dim_t src_col_eff, src_row_eff, out_col_eff, out_row_eff;
    acc_t col_acc_eff, row_acc_eff, col_step_eff, row_step_eff;
    logic done_eff;

    logic [DIM_BITS:0] want_col, want_row;
    logic hit;
    dim_t out_col_inc, out_row_inc;
    logic row_wrap, last;

    dim_t src_col_inc;

    dim_t src_col_next, src_row_next, out_col_next, out_row_next;
    acc_t col_acc_next, row_acc_next;
    logic done_next;

    // Move a request from the input register whenever the result slot can take it
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !step_busy && (!in_valid_reg || advance);

    assign degenerate = (cfg.dest_width <= dim_t'(1)) || (cfg.dest_height <= dim_t'(1)) ||
                        (cfg.dest_width > cfg.sample_width) ||
                        (cfg.dest_height > cfg.sample_height);

    // Restart the frame on a frame start request
    always_comb begin
        if (in_reg.frame_start) begin
            src_col_eff  = '0;
            src_row_eff  = '0;
            out_col_eff  = '0;
            out_row_eff  = '0;
            col_acc_eff  = '0;
            row_acc_eff  = '0;
            col_step_eff = degenerate ? '0 : col_quotient;
            row_step_eff = degenerate ? '0 : row_quotient;
            done_eff     = degenerate;
        end else begin
            src_col_eff  = src_col_reg;
            src_row_eff  = src_row_reg;
            out_col_eff  = out_col_reg;
            out_row_eff  = out_row_reg;
            col_acc_eff  = col_acc_reg;
            row_acc_eff  = row_acc_reg;
            col_step_eff = col_step_reg;
            row_step_eff = row_step_reg;
            done_eff     = done_reg;
        end
    end

    // Match the target source pixel and step the output position
    always_comb begin
        want_col    = {1'b0, cfg.crop_left} + {1'b0, col_acc_eff[ACC_BITS-1:FRAC_BITS]};
        want_row    = {1'b0, cfg.crop_top} + {1'b0, row_acc_eff[ACC_BITS-1:FRAC_BITS]};
        hit         = !done_eff && (want_col == {1'b0, src_col_eff}) &&
                      (want_row == {1'b0, src_row_eff});
        out_col_inc = out_col_eff + dim_t'(1);
        out_row_inc = out_row_eff + dim_t'(1);
        row_wrap    = (out_col_inc >= cfg.dest_width);
        last        = row_wrap && ((out_row_inc >= cfg.dest_height) || (out_row_inc == '0));

        out_col_next = out_col_eff;
        out_row_next = out_row_eff;
        col_acc_next = col_acc_eff;
        row_acc_next = row_acc_eff;
        done_next    = done_eff;
        if (hit) begin
            if (row_wrap) begin
                out_col_next = '0;
                col_acc_next = '0;
                out_row_next = out_row_inc;
                row_acc_next = row_acc_eff + row_step_eff;
                done_next    = last;
            end else begin
                out_col_next = out_col_inc;
                col_acc_next = col_acc_eff + col_step_eff;
            end
        end

        // Advance the source raster position
        src_col_inc = src_col_eff + dim_t'(1);
        if (src_col_inc == cfg.row_pixels) begin
            src_col_next = '0;
            src_row_next = src_row_eff + dim_t'(1);
        end else begin
            src_col_next = src_col_inc;
            src_row_next = src_row_eff;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            col_acc_reg   <= '0;
            row_acc_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            col_step_reg  <= '0;
            row_step_reg  <= '0;
            done_reg      <= 1'b1;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= hit;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance) begin
                src_col_reg  <= src_col_next;
                src_row_reg  <= src_row_next;
                col_acc_reg  <= col_acc_next;
                row_acc_reg  <= row_acc_next;
                out_col_reg  <= out_col_next;
                out_row_reg  <= out_row_next;
                col_step_reg <= col_step_eff;
                row_step_reg <= row_step_eff;
                done_reg     <= done_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance && hit) begin
            out_reg.pixel_out     <= in_reg.pixel_in;
            out_reg.out_column    <= out_col_eff;
            out_reg.out_row       <= out_row_eff;
            out_reg.last_of_frame <= last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> src/nearest_neighbor_pixel_scaler.sv
// Nearest-neighbor downscaler for a raster stream of 32-bit ARGB pixels. It takes one source
// pixel per clock while s_ready is high and passes on, unchanged, only those that land on the
// output grid, tagged with their output column and row and a flag on the frame's final output
// pixel. A request passes through an input register and then a result register. Writing
// sample_width, sample_height, dest_width or dest_height starts, in the cycle after the write
// lands, two restoring dividers that derive the 14.16 column and row steps one quotient bit
// per clock; s_ready is held low from the write until both are done. The steps are captured
// at each frame start, so write the sizes between frames.
module nearest_neighbor_pixel_scaler import nnps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  cfg_addr_t cfg_index,
    input  dim_t      cfg_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  nnps_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output nnps_out_t m_data
);

    nnps_cfg_t cfg_reg;
    logic      cfg_write;
    logic      size_write;
    logic      size_write_reg;
    logic      col_busy, row_busy;
    acc_t      col_quotient, row_quotient;
    acc_t      col_dividend, row_dividend;
    dim_t      col_divisor, row_divisor;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Any change of a size restarts the step computation
    assign size_write = cfg_write &&
                        ((cfg_index == CFG_SAMPLE_WIDTH) || (cfg_index == CFG_SAMPLE_HEIGHT) ||
                         (cfg_index == CFG_DEST_WIDTH) || (cfg_index == CFG_DEST_HEIGHT));

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_pixels    <= dim_t'(1);
            cfg_reg.crop_left     <= '0;
            cfg_reg.crop_top      <= '0;
            cfg_reg.sample_width  <= '0;
            cfg_reg.sample_height <= '0;
            cfg_reg.dest_width    <= '0;
            cfg_reg.dest_height   <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_ROW_PIXELS:    cfg_reg.row_pixels    <= cfg_data;
                CFG_CROP_LEFT:     cfg_reg.crop_left     <= cfg_data;
                CFG_CROP_TOP:      cfg_reg.crop_top      <= cfg_data;
                CFG_SAMPLE_WIDTH:  cfg_reg.sample_width  <= cfg_data;
                CFG_SAMPLE_HEIGHT: cfg_reg.sample_height <= cfg_data;
                CFG_DEST_WIDTH:    cfg_reg.dest_width    <= cfg_data;
                CFG_DEST_HEIGHT:   cfg_reg.dest_height   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Launch the dividers once the written size has landed in its register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_write_reg <= 1'b0;
        end else begin
            size_write_reg <= size_write;
        end
    end

    // Step = ((sample - 1) << FRAC_BITS) / (dest - 1)
    assign col_dividend = {dim_t'(cfg_reg.sample_width - dim_t'(1)), {FRAC_BITS{1'b0}}};
    assign row_dividend = {dim_t'(cfg_reg.sample_height - dim_t'(1)), {FRAC_BITS{1'b0}}};
    assign col_divisor  = cfg_reg.dest_width - dim_t'(1);
    assign row_divisor  = cfg_reg.dest_height - dim_t'(1);

    nnps_divider u_col_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (size_write_reg),
        .dividend (col_dividend),
        .divisor  (col_divisor),
        .busy     (col_busy),
        .quotient (col_quotient)
    );

    nnps_divider u_row_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (size_write_reg),
        .dividend (row_dividend),
        .divisor  (row_divisor),
        .busy     (row_busy),
        .quotient (row_quotient)
    );

    nnps_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .col_quotient (col_quotient),
        .row_quotient (row_quotient),
        .step_busy    (col_busy || row_busy || size_write || size_write_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

>>> test/nearest_neighbor_pixel_scaler_test.sv
module nearest_neighbor_pixel_scaler_test;
    import nnps_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    cfg_addr_t cfg_index = CFG_ROW_PIXELS;
    dim_t      cfg_data = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    nnps_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    nnps_out_t m_data;

    nearest_neighbor_pixel_scaler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #4 aclk = ~aclk;

    // Scaler geometry as last written, and the scan state it drives
    nnps_cfg_t geometry = '{row_pixels: 14'd1, default: '0};
    dim_t      src_col = '0;
    dim_t      src_row = '0;
    dim_t      out_col = '0;
    dim_t      out_row = '0;
    acc_t      col_acc = '0;
    acc_t      row_acc = '0;
    acc_t      col_step = '0;
    acc_t      row_step = '0;
    logic      frame_over = 1'b1;

    nnps_in_t    pixel_stream[$];
    nnps_out_t   expected_samples[$];
    int unsigned queued_items = 0;
    int unsigned mismatch_count = 0;
    bit          quiet = 1'b0;
    bit          pixel_taken = 1'b0;
    int unsigned send_gap = 0;
    int unsigned hold_left = 0;

    // Advance the scan by one source pixel; queue the sample it yields, if any
    function automatic void sample_pixel(input nnps_in_t item);
        int unsigned want_col;
        int unsigned want_row;
        nnps_out_t   hit;
        if (item.frame_start) begin
            src_col = '0;
            src_row = '0;
            col_acc = '0;
            row_acc = '0;
            out_col = '0;
            out_row = '0;
            if (geometry.dest_width <= 1 || geometry.dest_height <= 1 ||
                geometry.dest_width > geometry.sample_width ||
                geometry.dest_height > geometry.sample_height) begin
                col_step = '0;
                row_step = '0;
                frame_over = 1'b1;
            end else begin
                col_step = acc_t'(((64'(geometry.sample_width) - 64'd1) << FRAC_BITS) /
                                  (64'(geometry.dest_width) - 64'd1));
                row_step = acc_t'(((64'(geometry.sample_height) - 64'd1) << FRAC_BITS) /
                                  (64'(geometry.dest_height) - 64'd1));
                frame_over = 1'b0;
            end
        end

        if (!frame_over) begin
            want_col = 32'(geometry.crop_left) + 32'(col_acc >> FRAC_BITS);
            want_row = 32'(geometry.crop_top) + 32'(row_acc >> FRAC_BITS);
            if (want_col == 32'(src_col) && want_row == 32'(src_row)) begin
                hit.pixel_out     = item.pixel_in;
                hit.out_column    = out_col;
                hit.out_row       = out_row;
                hit.last_of_frame = 1'b0;
                out_col = out_col + 1'b1;
                col_acc = col_acc + col_step;
                // wrap to the next output row, close the frame after the last one
                if (out_col >= geometry.dest_width) begin
                    out_col = '0;
                    col_acc = '0;
                    out_row = out_row + 1'b1;
                    row_acc = row_acc + row_step;
                    if (out_row >= geometry.dest_height || out_row == '0) begin
                        hit.last_of_frame = 1'b1;
                        frame_over = 1'b1;
                    end
                end
                expected_samples.push_back(hit);
            end
        end

        src_col = src_col + 1'b1;
        if (src_col == geometry.row_pixels) begin
            src_col = '0;
            src_row = src_row + 1'b1;
        end
    endfunction

    // Mostly small sizes, now and then an extreme
    function automatic int unsigned pick_dim();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? 16383 : 0;
        end
        return $urandom_range(0, 12);
    endfunction

    task automatic queue_pixel(input pixel_t value, input logic start);
        nnps_in_t item;
        item.pixel_in    = value;
        item.frame_start = start;
        pixel_stream.push_back(item);
        queued_items++;
    endtask

    // One source frame; a broken one is cut short or restarted partway
    task automatic queue_frame(input int unsigned length, input bit broken);
        int unsigned restart_at;
        restart_at = length;
        if (broken) begin
            if ($urandom_range(0, 1)) begin
                length = $urandom_range(1, length);
            end else begin
                restart_at = $urandom_range(1, length);
            end
        end
        for (int unsigned k = 0; k < length; k++) begin
            queue_pixel($urandom(), k == 0 || k == restart_at);
        end
    endtask

    // Wait for the stream and the expected samples to empty, then let the pipe settle
    task automatic drain();
        @(posedge aclk);
        while (pixel_stream.size() != 0 || s_valid || expected_samples.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input dim_t value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_ROW_PIXELS:    geometry.row_pixels = value;
            CFG_CROP_LEFT:     geometry.crop_left = value;
            CFG_CROP_TOP:      geometry.crop_top = value;
            CFG_SAMPLE_WIDTH:  geometry.sample_width = value;
            CFG_SAMPLE_HEIGHT: geometry.sample_height = value;
            CFG_DEST_WIDTH:    geometry.dest_width = value;
            CFG_DEST_HEIGHT:   geometry.dest_height = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned rp, input int unsigned cl,
                                input int unsigned ct, input int unsigned sw,
                                input int unsigned sh, input int unsigned dw,
                                input int unsigned dh);
        drain();
        write_reg(CFG_ROW_PIXELS, dim_t'(rp));
        write_reg(CFG_CROP_LEFT, dim_t'(cl));
        write_reg(CFG_CROP_TOP, dim_t'(ct));
        write_reg(CFG_SAMPLE_WIDTH, dim_t'(sw));
        write_reg(CFG_SAMPLE_HEIGHT, dim_t'(sh));
        write_reg(CFG_DEST_WIDTH, dim_t'(dw));
        write_reg(CFG_DEST_HEIGHT, dim_t'(dh));
    endtask

    // Capture accepted source pixels
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sample_pixel(s_data);
            pixel_taken = 1'b1;
        end
    end

    // Present the next source pixel, with random gaps between requests
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || pixel_taken) begin
            pixel_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                s_valid <= 1'b0;
            end else if (pixel_stream.size() > 0) begin
                s_data  <= pixel_stream.pop_front();
                s_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 4);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Stall the result channel in random bursts
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 4) == 0) begin
                hold_left = $urandom_range(1, 4);
            end
        end
    end

    // Check each result against the oldest expected sample
    always @(posedge aclk) begin
        nnps_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                mismatch_count++;
            end else begin
                want = expected_samples.pop_front();
                if (m_data.pixel_out !== want.pixel_out) begin
                    $display("%0t: pixel_out expected %h, got %h",
                             $time, want.pixel_out, m_data.pixel_out);
                    mismatch_count++;
                end
                if (m_data.out_column !== want.out_column) begin
                    $display("%0t: out_column expected %0d, got %0d",
                             $time, want.out_column, m_data.out_column);
                    mismatch_count++;
                end
                if (m_data.out_row !== want.out_row) begin
                    $display("%0t: out_row expected %0d, got %0d",
                             $time, want.out_row, m_data.out_row);
                    mismatch_count++;
                end
                if (m_data.last_of_frame !== want.last_of_frame) begin
                    $display("%0t: last_of_frame expected %b, got %b",
                             $time, want.last_of_frame, m_data.last_of_frame);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int unsigned     rp, cl, ct, sw, sh, dw, dh;
        int unsigned     base;
        longint unsigned span;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Before any frame start nothing comes out; degenerate reset sizes on a start
        queue_pixel('0, 1'b0);
        queue_pixel('1, 1'b0);
        queue_pixel($urandom(), 1'b1);

        // 3x3 region down to 2x2, extreme pixel values on the two top sampled corners
        set_geometry(3, 0, 0, 3, 3, 2, 2);
        for (int k = 0; k < 9; k++) begin
            queue_pixel(k == 0 ? '1 : k == 2 ? '0 : $urandom(), k == 0);
        end

        // Cropped region offset by one column and one row
        set_geometry(3, 1, 1, 2, 2, 2, 2);
        queue_frame(9, 1'b0);

        // All registers at their maximum: the target lies off the row and never matches
        set_geometry(16383, 16383, 16383, 16383, 16383, 16383, 16383);
        queue_pixel('1, 1'b1);
        queue_pixel('0, 1'b0);

        // Zero row length: the row runs the full counter range
        set_geometry(0, 0, 0, 2, 2, 2, 2);
        queue_frame(3, 1'b0);

        // Sampled region starts several rows down; rows past it stream by unmatched
        set_geometry(2, 0, 3, 2, 2, 2, 2);
        queue_frame(14, 1'b0);

        // Random geometries, mostly well-formed frames
        base = queued_items;
        while (queued_items - base < 800) begin
            quiet = (queued_items - base > 680);
            if ($urandom_range(0, 3) != 0) begin
                rp = $urandom_range(2, 10);
                sw = $urandom_range(2, rp);
                cl = $urandom_range(0, rp - sw);
                sh = $urandom_range(2, 5);
                ct = $urandom_range(0, 2);
                dw = $urandom_range(2, sw);
                dh = $urandom_range(2, sh);
            end else begin
                rp = pick_dim();
                cl = pick_dim();
                ct = pick_dim();
                sw = pick_dim();
                sh = pick_dim();
                dw = pick_dim();
                dh = pick_dim();
            end
            set_geometry(rp, cl, ct, sw, sh, dw, dh);
            // continue the previous frame under the new registers
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    queue_pixel($urandom(), $urandom_range(0, 3) == 0);
                end
            end
            repeat ($urandom_range(1, 3)) begin
                span = 64'(rp == 0 ? 16384 : rp) * 64'(ct + sh) + $urandom_range(0, 3);
                if (span > 300) span = 300;
                if (span == 0) span = 1;
                queue_frame(int'(span), $urandom_range(0, 7) == 0);
            end
        end

        drain();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> nearest_neighbor_pixel_scaler.f
src/nnps_pkg.sv
src/nnps_divider.sv
src/nnps_core.sv
src/nearest_neighbor_pixel_scaler.sv
test/nearest_neighbor_pixel_scaler_test.sv
